@@ hw/rtl/ges_pkg.sv @@
// ----------------------------------------------------------------------------
// ges_pkg
// Shared constants, register indexes, state codes and the command and status
// structs that join the solver controller and datapath.
// ----------------------------------------------------------------------------
package ges_pkg;

    localparam int MAX_N       = 16;
    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int STORE_DEPTH = MAX_N * (MAX_N + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LC_W        = $clog2(STORE_DEPTH + 1);
    localparam int ROW_W       = $clog2(MAX_N + 1);
    localparam int IDX_W       = $clog2(MAX_N);
    localparam int SIDX_W      = 4;
    localparam int SIZE_W      = 5;
    localparam int THR_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_W       = WORD_W + FRAC_BITS;
    localparam int DIVC_W      = $clog2(DIV_W + 1);
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 40;

    localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(2);
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_SIZE,
        CFG_PIVOT_THRESHOLD
    } ges_cfg_idx_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_F_PIV_RD,
        S_F_PIV_CHK,
        S_F_FAC_RD,
        S_F_FAC_DIV,
        S_F_FAC_WAIT,
        S_F_MUL_RD,
        S_F_MUL,
        S_F_SUB,
        S_B_RHS_RD,
        S_B_RHS,
        S_B_TRM_RD,
        S_B_TRM_MUL,
        S_B_TRM_SUB,
        S_B_DIAG_RD,
        S_B_DIV,
        S_B_WAIT,
        S_OUT
    } ges_state_t;

    typedef struct packed {
        logic             load_en;
        logic             rd_en;
        logic             wr_en;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             piv_cap;
        logic             div_start;
        logic             div_back;
        logic             f_cap;
        logic             mul_en;
        logic             mul_back;
        logic             acc_init;
        logic             acc_sub;
        logic             sol_wr;
        logic             out_load;
        logic             out_null;
    } ges_cmd_t;

    typedef struct packed {
        logic             load_done;
        logic             piv_null;
        logic             div_done;
        logic             out_last;
        logic [ROW_W-1:0] n_act;
    } ges_sts_t;

endpackage

@@ hw/rtl/ges_div.sv @@
// ----------------------------------------------------------------------------
// ges_div
// Radix-2 restoring divider: signed fixed-point quotient (a * 2^F) / b,
// truncated toward zero and saturated to one word; a zero divisor gives zero. One bit per cycle.
// ----------------------------------------------------------------------------
module ges_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [ges_pkg::WORD_W-1:0] dividend,
    input  logic signed [ges_pkg::WORD_W-1:0] divisor,
    output logic                              done,
    output logic signed [ges_pkg::WORD_W-1:0] quotient
);

    localparam int W  = ges_pkg::WORD_W;
    localparam int DW = ges_pkg::DIV_W;
    localparam int CW = ges_pkg::DIVC_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;

    logic [W-1:0]  a_mag, b_mag;
    logic [W:0]    trial, diff;
    logic          ge;
    logic          hi_any, pos_over, neg_over;

    always_comb begin
        a_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
        b_mag = divisor[W-1] ? (~divisor + W'(1)) : divisor;
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            rem_next  = '0;
            quo_next  = {a_mag, {ges_pkg::FRAC_BITS{1'b0}}};
            den_next  = b_mag;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // saturate the magnitude with its sign applied
    always_comb begin
        hi_any   = |quo_reg[DW-1:W];
        pos_over = hi_any | quo_reg[W-1];
        neg_over = hi_any | (quo_reg[W-1] & (|quo_reg[W-2:0]));
        if (zero_reg) begin
            quotient = '0;
        end else if (neg_reg) begin
            quotient = neg_over ? {1'b1, {(W-1){1'b0}}} : -$signed(quo_reg[W-1:0]);
        end else begin
            quotient = pos_over ? {1'b0, {(W-1){1'b1}}} : $signed(quo_reg[W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/ges_datapath.sv @@
// ----------------------------------------------------------------------------
// ges_datapath
// Matrix store, solution registers, multiplier, saturating subtract, divider,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module ges_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ges_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [ges_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic signed [ges_pkg::WORD_W-1:0]     element_value,
    input  ges_pkg::ges_cmd_t                     cmd,
    output ges_pkg::ges_sts_t                     sts,
    output logic signed [ges_pkg::WORD_W-1:0]     solution_value,
    output logic [ges_pkg::SIDX_W-1:0]            solution_index,
    output logic                                  status,
    output logic                                  last_result
);

    localparam int W = ges_pkg::WORD_W;

    logic [ges_pkg::SIZE_W-1:0] size_reg;
    logic [ges_pkg::THR_W-1:0]  thr_reg;
    logic [ges_pkg::LC_W-1:0]   lc_reg, lc_next;

    logic signed [W-1:0] mem [ges_pkg::STORE_DEPTH];
    logic signed [W-1:0] rdata_reg;
    logic signed [W-1:0] sol_reg [ges_pkg::MAX_N];
    logic signed [W-1:0] piv_reg, f_reg, acc_reg;
    logic signed [2*W-1:0] prod_reg;

    logic signed [W-1:0] out_value_reg;
    logic [ges_pkg::SIDX_W-1:0] out_index_reg;
    logic out_status_reg, out_last_reg;

    logic [ges_pkg::ROW_W-1:0]  n_act;
    logic [ges_pkg::LC_W-1:0]   n_ext, total, lc_inc, cell_addr;
    logic [ges_pkg::ADDR_W-1:0] addr;
    logic signed [W-1:0]        wdata, term, acc_diff, mul_a, div_a, div_b, div_q;
    logic signed [2*W-1:0]      prod_sh;
    logic [W:0]                 piv_mag;
    logic                       div_done;

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] d;
        d = {a[W-1], a} - {b[W-1], b};
        if (d[W] != d[W-1]) begin
            return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return d[W-1:0];
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= ges_pkg::SIZE_RST;
            thr_reg  <= ges_pkg::THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ges_pkg::CFG_MATRIX_SIZE:     size_reg <= cfg_wr_data[ges_pkg::SIZE_W-1:0];
                ges_pkg::CFG_PIVOT_THRESHOLD: thr_reg  <= cfg_wr_data[ges_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (size_reg == '0) begin
            n_act = ges_pkg::ROW_W'(1);
        end else if (int'(size_reg) > ges_pkg::MAX_N) begin
            n_act = ges_pkg::ROW_W'(ges_pkg::MAX_N);
        end else begin
            n_act = ges_pkg::ROW_W'(size_reg);
        end
        n_ext     = ges_pkg::LC_W'(n_act);
        total     = n_ext * (n_ext + ges_pkg::LC_W'(1));
        lc_inc    = lc_reg + ((lc_reg < ges_pkg::LC_W'(ges_pkg::STORE_DEPTH)) ?
                              ges_pkg::LC_W'(1) : ges_pkg::LC_W'(0));
        cell_addr = ges_pkg::LC_W'(cmd.row) * (n_ext + ges_pkg::LC_W'(1))
                    + ges_pkg::LC_W'(cmd.col);
        addr      = cmd.load_en ? lc_reg[ges_pkg::ADDR_W-1:0]
                                : cell_addr[ges_pkg::ADDR_W-1:0];
        lc_next   = lc_reg;
        if (cmd.load_en) begin
            lc_next = (lc_inc >= total) ? '0 : lc_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg <= '0;
        end else begin
            lc_reg <= lc_next;
        end
    end

    // arithmetic
    always_comb begin
        prod_sh = prod_reg >>> ges_pkg::FRAC_BITS;
        if ((&prod_sh[2*W-1:W-1]) || !(|prod_sh[2*W-1:W-1])) begin
            term = prod_sh[W-1:0];
        end else begin
            term = prod_sh[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        wdata    = cmd.load_en ? element_value : sat_sub(rdata_reg, term);
        acc_diff = sat_sub(acc_reg, term);
        mul_a    = cmd.mul_back ? sol_reg[cmd.col[ges_pkg::IDX_W-1:0]] : f_reg;
        div_a    = cmd.div_back ? acc_reg : rdata_reg;
        div_b    = cmd.div_back ? rdata_reg : piv_reg;
        piv_mag  = rdata_reg[W-1] ? -{rdata_reg[W-1], rdata_reg} : {1'b0, rdata_reg};
    end

    // single-port store: load beats, reads and write-backs never share a cycle
    always_ff @(posedge aclk) begin
        if ((cmd.load_en && (lc_reg < ges_pkg::LC_W'(ges_pkg::STORE_DEPTH))) || cmd.wr_en) begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    ges_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.piv_cap) piv_reg <= rdata_reg;
        if (cmd.f_cap) f_reg <= div_q;
        if (cmd.mul_en) prod_reg <= mul_a * rdata_reg;
        if (cmd.acc_init) begin
            acc_reg <= rdata_reg;
        end else if (cmd.acc_sub) begin
            acc_reg <= acc_diff;
        end
        if (cmd.sol_wr) sol_reg[cmd.row[ges_pkg::IDX_W-1:0]] <= div_q;
        if (cmd.out_load) begin
            if (cmd.out_null) begin
                out_value_reg  <= '0;
                out_index_reg  <= '0;
                out_status_reg <= 1'b1;
                out_last_reg   <= 1'b1;
            end else begin
                out_value_reg  <= div_q;
                out_index_reg  <= cmd.row[ges_pkg::SIDX_W-1:0];
                out_status_reg <= 1'b0;
                out_last_reg   <= (cmd.row == '0);
            end
        end
    end

    always_comb begin
        sts.load_done = lc_inc >= total;
        sts.piv_null  = (rdata_reg == '0) || (piv_mag < (W+1)'(thr_reg));
        sts.div_done  = div_done;
        sts.out_last  = out_last_reg;
        sts.n_act     = n_act;
    end

    assign solution_value = out_value_reg;
    assign solution_index = out_index_reg;
    assign status         = out_status_reg;
    assign last_result    = out_last_reg;

endmodule

@@ hw/rtl/ges_ctrl.sv @@
// ----------------------------------------------------------------------------
// ges_ctrl
// Sequencer for loading, forward elimination, back substitution and result
// hand-off. Holds the loop counters k, i and j.
// ----------------------------------------------------------------------------
module ges_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ges_pkg::ges_sts_t sts,
    output ges_pkg::ges_cmd_t cmd
);

    localparam int RW = ges_pkg::ROW_W;

    ges_pkg::ges_state_t state_reg, state_next;
    logic [RW-1:0] k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [RW-1:0] n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ges_pkg::S_LOAD;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb begin
        n          = sts.n_act;
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.row    = i_reg;
        cmd.col    = j_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        case (state_reg)
            ges_pkg::S_LOAD: begin
                s_tready    = 1'b1;
                cmd.load_en = s_tvalid;
                if (s_tvalid && sts.load_done) begin
                    k_next     = '0;
                    state_next = ges_pkg::S_F_PIV_RD;
                end
            end
            ges_pkg::S_F_PIV_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.row    = k_reg;
                cmd.col    = k_reg;
                state_next = ges_pkg::S_F_PIV_CHK;
            end
            ges_pkg::S_F_PIV_CHK: begin
                cmd.piv_cap = 1'b1;
                if (sts.piv_null) begin
                    cmd.out_load = 1'b1;
                    cmd.out_null = 1'b1;
                    state_next   = ges_pkg::S_OUT;
                end else if (k_reg + RW'(1) < n) begin
                    i_next     = k_reg + RW'(1);
                    state_next = ges_pkg::S_F_FAC_RD;
                end else begin
                    i_next     = n - RW'(1);
                    state_next = ges_pkg::S_B_RHS_RD;
                end
            end
            ges_pkg::S_F_FAC_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.col    = k_reg;
                state_next = ges_pkg::S_F_FAC_DIV;
            end
            ges_pkg::S_F_FAC_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ges_pkg::S_F_FAC_WAIT;
            end
            ges_pkg::S_F_FAC_WAIT: begin
                if (sts.div_done) begin
                    cmd.f_cap  = 1'b1;
                    j_next     = k_reg;
                    state_next = ges_pkg::S_F_MUL_RD;
                end
            end
            ges_pkg::S_F_MUL_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.row    = k_reg;
                state_next = ges_pkg::S_F_MUL;
            end
            ges_pkg::S_F_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.rd_en  = 1'b1;
                state_next = ges_pkg::S_F_SUB;
            end
            ges_pkg::S_F_SUB: begin
                cmd.wr_en = 1'b1;
                if (j_reg < n) begin
                    j_next     = j_reg + RW'(1);
                    state_next = ges_pkg::S_F_MUL_RD;
                end else if (i_reg + RW'(1) < n) begin
                    i_next     = i_reg + RW'(1);
                    state_next = ges_pkg::S_F_FAC_RD;
                end else begin
                    k_next     = k_reg + RW'(1);
                    state_next = ges_pkg::S_F_PIV_RD;
                end
            end
            ges_pkg::S_B_RHS_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.col    = n;
                state_next = ges_pkg::S_B_RHS;
            end
            ges_pkg::S_B_RHS: begin
                cmd.acc_init = 1'b1;
                if (i_reg + RW'(1) < n) begin
                    j_next     = i_reg + RW'(1);
                    state_next = ges_pkg::S_B_TRM_RD;
                end else begin
                    state_next = ges_pkg::S_B_DIAG_RD;
                end
            end
            ges_pkg::S_B_TRM_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ges_pkg::S_B_TRM_MUL;
            end
            ges_pkg::S_B_TRM_MUL: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_back = 1'b1;
                state_next   = ges_pkg::S_B_TRM_SUB;
            end
            ges_pkg::S_B_TRM_SUB: begin
                cmd.acc_sub = 1'b1;
                if (j_reg + RW'(1) < n) begin
                    j_next     = j_reg + RW'(1);
                    state_next = ges_pkg::S_B_TRM_RD;
                end else begin
                    state_next = ges_pkg::S_B_DIAG_RD;
                end
            end
            ges_pkg::S_B_DIAG_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.col    = i_reg;
                state_next = ges_pkg::S_B_DIV;
            end
            ges_pkg::S_B_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_back  = 1'b1;
                state_next    = ges_pkg::S_B_WAIT;
            end
            ges_pkg::S_B_WAIT: begin
                if (sts.div_done) begin
                    cmd.sol_wr   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ges_pkg::S_OUT;
                end
            end
            ges_pkg::S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (sts.out_last) begin
                        state_next = ges_pkg::S_LOAD;
                    end else begin
                        i_next     = i_reg - RW'(1);
                        state_next = ges_pkg::S_B_RHS_RD;
                    end
                end
            end
            default: begin
                state_next = ges_pkg::S_LOAD;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels open together");

    a_port_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && (cmd.wr_en || cmd.load_en)))
        else $error("store read clashes with a write");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(i_reg)))
        else $error("stalled result dropped");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !sts.div_done)
        else $error("divider done too early");

endmodule

@@ hw/rtl/gaussian_elimination_solver.sv @@
// Load: one element beat per cycle in the load state; n*(n+1) beats per system.
// Forward elimination: per pivot a read and a check; per row below it a read, a
// divider start and a wait, then per column two reads, a multiply and a write-back.
// Back substitution: per unknown a right-hand-side read, per term a read, multiply
// and subtract, then a diagonal read, a divide and a wait, then one result beat.
// Reset (aresetn low, synchronous): load count cleared, size 2, threshold 1.
// ----------------------------------------------------------------------------
// gaussian_elimination_solver
// Gaussian elimination without row swaps and back substitution on a Q16.16
// augmented matrix; emits the solution from the last unknown down, or one
// singular-status beat when a pivot is null.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ges_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ges_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ges_pkg::S_DATA_W-1:0]      s_tdata,   // [31:0] element_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ges_pkg::M_DATA_W-1:0]      m_tdata,   // [31:0] solution_value,
                                                         // [35:32] solution_index
    output logic                              m_tuser,   // [0] status
    output logic                              m_tlast    // last_result
);

    ges_pkg::ges_cmd_t cmd;
    ges_pkg::ges_sts_t sts;
    logic signed [ges_pkg::WORD_W-1:0] solution_value;
    logic [ges_pkg::SIDX_W-1:0]        solution_index;

    ges_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ges_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .element_value  (s_tdata[ges_pkg::WORD_W-1:0]),
        .cmd            (cmd),
        .sts            (sts),
        .solution_value (solution_value),
        .solution_index (solution_index),
        .status         (m_tuser),
        .last_result    (m_tlast)
    );

    assign m_tdata = {{(ges_pkg::M_DATA_W - ges_pkg::WORD_W - ges_pkg::SIDX_W){1'b0}},
                      solution_index, solution_value};

endmodule

@@ bench/gaussian_elimination_solver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_tb
// Streams augmented matrices into the solver at several sizes and thresholds,
// predicts the solution beats or the singular-status beat in fixed point, and
// checks every result beat field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_tb;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic               status;
        logic               last;
    } sol_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [ges_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [ges_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ges_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ges_pkg::M_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    gaussian_elimination_solver dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic signed [31:0] mat_copy [ges_pkg::STORE_DEPTH];
    logic signed [31:0] sol_copy [ges_pkg::MAX_N];
    int unsigned load_cnt = 0;
    int unsigned size_reg = 2;
    int unsigned thr_reg = 1;

    logic signed [31:0] element_queue [$];
    sol_beat_t solution_queue [$];
    int errors = 0;
    bit calm = 0;

    // handshake seen at the last rising edge
    logic s_tready_seen = 1'b0;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p >>> ges_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        longint num;
        if (b == 0) return 0;
        num = longint'(a) * (64'sd1 << ges_pkg::FRAC_BITS);
        return sat32(num / longint'(b));
    endfunction

    function automatic int unsigned at(int unsigned r, int unsigned c, int unsigned n);
        return (r * (n + 1) + c) % ges_pkg::STORE_DEPTH;
    endfunction

    task automatic solve_system(int unsigned n);
        logic signed [31:0] piv, f, s;
        longint mag;
        sol_beat_t b;
        for (int k = 0; k < n; k++) begin
            piv = mat_copy[at(k, k, n)];
            mag = piv < 0 ? -longint'(piv) : longint'(piv);
            if (piv == 0 || mag < thr_reg) begin
                b = '{value: 0, index: 0, status: 1'b1, last: 1'b1};
                solution_queue.push_back(b);
                return;
            end
            for (int i = k + 1; i < n; i++) begin
                f = q_div(mat_copy[at(i, k, n)], piv);
                for (int j = k; j <= n; j++)
                    mat_copy[at(i, j, n)] = sat32(longint'(mat_copy[at(i, j, n)])
                        - longint'(q_mul(f, mat_copy[at(k, j, n)])));
            end
        end
        for (int i = n - 1; i >= 0; i--) begin
            s = mat_copy[at(i, n, n)];
            for (int j = i + 1; j < n; j++)
                s = sat32(longint'(s) - longint'(q_mul(mat_copy[at(i, j, n)], sol_copy[j])));
            sol_copy[i] = q_div(s, mat_copy[at(i, i, n)]);
            b = '{value: sol_copy[i], index: 4'(i), status: 1'b0, last: (i == 0)};
            solution_queue.push_back(b);
        end
    endtask

    task automatic accept_element(logic signed [31:0] v);
        int unsigned n;
        n = size_reg == 0 ? 1 : (size_reg > ges_pkg::MAX_N ? ges_pkg::MAX_N : size_reg);
        if (load_cnt < ges_pkg::STORE_DEPTH) begin
            mat_copy[load_cnt] = v;
            load_cnt++;
        end
        if (load_cnt >= n * (n + 1)) begin
            load_cnt = 0;
            solve_system(n);
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (element_queue.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= element_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || $urandom_range(99) >= 14;
        end
    end

    // monitor
    always @(posedge aclk) begin
        sol_beat_t got, want;
        s_tready_seen <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            accept_element(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            got = '{value: m_tdata[31:0], index: m_tdata[35:32], status: m_tuser,
                    last: m_tlast};
            if (solution_queue.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
            end else begin
                want = solution_queue.pop_front();
                if (got.value !== want.value) begin
                    $error("solution_value exp %0d got %0d", want.value, got.value);
                    errors++;
                end
                if (got.index !== want.index) begin
                    $error("solution_index exp %0d got %0d", want.index, got.index);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_result exp %0d got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (element_queue.size() > 0 || s_tvalid || solution_queue.size() > 0)
            @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic write_reg(ges_pkg::ges_cfg_idx_t idx, int unsigned val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= ges_pkg::CFG_W'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == ges_pkg::CFG_MATRIX_SIZE) size_reg = val & 5'h1f;
        else thr_reg = val & 16'hffff;
    endtask

    function automatic logic signed [31:0] rand_elem(bit diag);
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: begin
                // moderate Q16.16 values, diagonal kept strong
                if (diag) return ($urandom_range(1) ? 1 : -1)
                                 * int'($urandom_range(20 << 16, 4 << 16));
                return int'($urandom_range(6 << 16)) - (3 << 16);
            end
        endcase
    endfunction

    task automatic push_system(int unsigned n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                element_queue.push_back(rand_elem(r == c));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset size 2, a zero pivot, extremes
        element_queue = '{32'sh00010000, 32'sh7fffffff, 32'sh80000000,
                          32'sh80000000, 32'sh00020000, 32'sh7fffffff};
        element_queue.push_back(0); element_queue.push_back(1);
        element_queue.push_back(2); element_queue.push_back(3);
        element_queue.push_back(4); element_queue.push_back(5);
        wait_drained();
        write_reg(ges_pkg::CFG_MATRIX_SIZE, 0);      // treated as one
        write_reg(ges_pkg::CFG_PIVOT_THRESHOLD, 0);
        element_queue = '{32'sh00000001, 32'shffffffff, 32'sh00000000, 32'sh12345678};
        wait_drained();
        write_reg(ges_pkg::CFG_PIVOT_THRESHOLD, 65535);
        element_queue = '{32'sh0000ffff, 32'sh00050000, 32'shffff0001, 32'sh7fffffff};
        wait_drained();

        // random systems, mostly small
        for (int p = 0; p < 11; p++) begin
            int unsigned sz;
            sz = $urandom_range(4, 1);
            calm = (p >= 4 && p <= 6);
            write_reg(ges_pkg::CFG_MATRIX_SIZE, sz);
            write_reg(ges_pkg::CFG_PIVOT_THRESHOLD,
                      $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(16));
            push_system(sz);
            wait_drained();
        end
        calm = 0;

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end
endmodule

@@ gaussian_elimination_solver.f @@
hw/rtl/ges_pkg.sv
hw/rtl/ges_div.sv
hw/rtl/ges_datapath.sv
hw/rtl/ges_ctrl.sv
hw/rtl/gaussian_elimination_solver.sv
bench/gaussian_elimination_solver_tb.sv
